FILE: src/ftos_pkg.sv
// ftos_pkg: widths, types and constants of the force/torque offset smoother
// shared by the top level, its port checker and the testbench; depends on nothing
package ftos_pkg;

	localparam int CAL_SAMPLES = 40;
	localparam int AXES        = 6;
	localparam int AXIS_W      = $clog2(AXES);
	localparam int IN_W        = 24;
	localparam int SUM_W       = 30;
	localparam int AVG_W       = 25;
	localparam int SMO_W       = AVG_W + 3;
	localparam int SQ_W        = 2 * AVG_W;
	localparam int REM_W       = AVG_W + 3;
	localparam int DIV_W       = $clog2(CAL_SAMPLES + 1);
	localparam int CNT_W       = $clog2(CAL_SAMPLES + 2);
	localparam int STEP_W      = $clog2(SUM_W + 2);
	localparam int IN_DATA_W   = AXES * IN_W;
	localparam int OUT_DATA_W  = (AXES + 2) * AVG_W;
	localparam int MAG_MAX     = 29058990;

	typedef logic signed [IN_W-1:0]  sample_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [AVG_W-1:0] avg_t;
	typedef logic signed [SMO_W-1:0] smo_t;

endpackage

FILE: src/force_torque_offset_smoother.sv
// force_torque_offset_smoother: bias calibration, smoothing and magnitudes of six-axis samples
// bit-serial divider, multiplier and square root on rotating axis rings; uses ftos_pkg
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: six 24-bit samples, s_tuser: mode
// m_        out  m_tvalid/m_tready  m_tdata: six 25-bit averages, two magnitudes
// cfg_      in   cfg_valid/cfg_ready cfg_data: enable
//
// word handling: a clear or disabled word is done in idle, a calibration word adds into each axis sum
// a mean word is divided axis by axis by the radix-2 divider
// a result word is smoothed, then squared and rooted by the bit-serial square/root
// arst_n clears state, counters and enable (to 1); no word taken while busy
// a finished word waits in the output register; the next word is taken meanwhile, and a
// second finished word holds in the last stage, stalling input, until the register drains
module force_torque_offset_smoother (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// force_x, force_y, force_z, torque_x, torque_y, torque_z
	input  logic [ftos_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// avg_force_x, avg_force_y, avg_force_z, avg_torque_x, avg_torque_y, avg_torque_z,
	// force_magnitude, torque_magnitude
	output logic [ftos_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CAL    = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_SMOOTH = 3'd3;
	localparam logic [2:0] ST_SQ     = 3'd4;
	localparam logic [2:0] ST_ROOT   = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	localparam logic [ftos_pkg::AXIS_W-1:0] AXIS_LAST  = ftos_pkg::AXIS_W'(ftos_pkg::AXES - 1);
	localparam logic [ftos_pkg::AXIS_W-1:0] FORCE_LAST = ftos_pkg::AXIS_W'(2);
	localparam logic [ftos_pkg::STEP_W-1:0] DIV_LAST   = ftos_pkg::STEP_W'(ftos_pkg::SUM_W + 1);
	localparam logic [ftos_pkg::STEP_W-1:0] SQ_LAST    = ftos_pkg::STEP_W'(ftos_pkg::AVG_W);
	localparam logic [ftos_pkg::STEP_W-1:0] ROOT_LAST  = ftos_pkg::STEP_W'(ftos_pkg::AVG_W - 1);

	logic [2:0]                        state_q;
	logic [ftos_pkg::AXIS_W-1:0]       axis_q;
	logic [ftos_pkg::STEP_W-1:0]       step_q;
	logic [ftos_pkg::CNT_W-1:0]        cal_cnt_q;
	logic                              enable_q;
	logic                              m_tvalid_q;
	ftos_pkg::sum_t                    off_q [ftos_pkg::AXES];
	ftos_pkg::avg_t                    sm_q [ftos_pkg::AXES];
	ftos_pkg::sample_t                 x_q [ftos_pkg::AXES];

	logic [ftos_pkg::SUM_W-1:0]        dq_q;
	logic [ftos_pkg::DIV_W-1:0]        drem_q;
	logic                              neg_q;
	logic [ftos_pkg::SQ_W-1:0]         mcand_q;
	logic [ftos_pkg::AVG_W-1:0]        mpl_q;
	logic [ftos_pkg::SQ_W-1:0]         acc_q;
	logic [ftos_pkg::REM_W-1:0]        srem_q;
	logic [ftos_pkg::AVG_W-1:0]        root_q;
	logic [ftos_pkg::AVG_W-1:0]        fmag_q;
	logic [ftos_pkg::AVG_W-1:0]        tmag_q;
	logic [ftos_pkg::OUT_DATA_W-1:0]   out_q;

	ftos_pkg::sum_t                    cal_sum;
	logic [ftos_pkg::SUM_W-1:0]        off_abs;
	logic [ftos_pkg::DIV_W:0]          div_r;
	logic [ftos_pkg::DIV_W:0]          div_sub;
	logic                              div_ge;
	logic [ftos_pkg::DIV_W-1:0]        drem_d;
	ftos_pkg::sum_t                    mean_wb;
	ftos_pkg::avg_t                    mean_c;
	ftos_pkg::avg_t                    x_c;
	ftos_pkg::avg_t                    corr;
	ftos_pkg::smo_t                    sm_ext;
	ftos_pkg::smo_t                    smo_sum;
	ftos_pkg::avg_t                    sm_new;
	logic [ftos_pkg::AVG_W-1:0]        sm_abs;
	logic [ftos_pkg::REM_W-1:0]        root_r;
	logic [ftos_pkg::REM_W-1:0]        trial;
	logic                              root_ge;
	logic [ftos_pkg::REM_W-1:0]        srem_d;
	logic [ftos_pkg::AVG_W-1:0]        root_d;
	logic                              out_load;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = out_q;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// calibration accumulate
	assign cal_sum = off_q[0] + ftos_pkg::sum_t'(x_q[0]);

	// radix-2 restoring divide by the sample count
	assign off_abs = off_q[0][ftos_pkg::SUM_W-1] ? (ftos_pkg::SUM_W'(0) - off_q[0]) : off_q[0];
	assign div_r   = {drem_q, dq_q[ftos_pkg::SUM_W-1]};
	assign div_ge  = (div_r >= (ftos_pkg::DIV_W + 1)'(ftos_pkg::CAL_SAMPLES));
	assign div_sub = div_r - (ftos_pkg::DIV_W + 1)'(ftos_pkg::CAL_SAMPLES);
	assign drem_d  = div_ge ? div_sub[ftos_pkg::DIV_W-1:0] : div_r[ftos_pkg::DIV_W-1:0];
	assign mean_wb = neg_q ? ftos_pkg::sum_t'(ftos_pkg::SUM_W'(0) - dq_q) : ftos_pkg::sum_t'(dq_q);

	// offset correction and smoothing of the head axis
	assign mean_c  = off_q[0][ftos_pkg::AVG_W-1:0];
	assign x_c     = ftos_pkg::AVG_W'(x_q[0]);
	assign corr    = mean_c - x_c;
	assign sm_ext  = ftos_pkg::SMO_W'(sm_q[0]);
	assign smo_sum = (sm_ext <<< 1) + sm_ext + ftos_pkg::SMO_W'(corr);
	assign sm_new  = smo_sum[ftos_pkg::AVG_W+1:2];

	assign sm_abs = sm_q[0][ftos_pkg::AVG_W-1] ? (ftos_pkg::AVG_W'(0) - sm_q[0]) : sm_q[0];

	// one result bit per cycle of the square root
	assign root_r  = {srem_q[ftos_pkg::REM_W-3:0], acc_q[ftos_pkg::SQ_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign root_ge = (root_r >= trial);
	assign srem_d  = root_ge ? (root_r - trial) : root_r;
	assign root_d  = {root_q[ftos_pkg::AVG_W-2:0], root_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			axis_q     <= '0;
			step_q     <= '0;
			cal_cnt_q  <= '0;
			enable_q   <= 1'b1;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < ftos_pkg::AXES; i++) begin
				off_q[i] <= '0;
				sm_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid) begin
				enable_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						axis_q <= '0;
						step_q <= '0;
						if (s_tuser) begin
							cal_cnt_q <= '0;
							for (int i = 0; i < ftos_pkg::AXES; i++) begin
								off_q[i] <= '0;
								sm_q[i]  <= '0;
							end
						end else if (enable_q) begin
							if (cal_cnt_q < ftos_pkg::CNT_W'(ftos_pkg::CAL_SAMPLES)) begin
								state_q <= ST_CAL;
							end else if (cal_cnt_q == ftos_pkg::CNT_W'(ftos_pkg::CAL_SAMPLES)) begin
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_SMOOTH;
							end
						end
					end
				end
				ST_CAL: begin
					for (int i = 0; i < ftos_pkg::AXES - 1; i++) begin
						off_q[i] <= off_q[i+1];
					end
					off_q[ftos_pkg::AXES-1] <= cal_sum;
					if (axis_q == AXIS_LAST) begin
						axis_q    <= '0;
						cal_cnt_q <= cal_cnt_q + 1'b1;
						state_q   <= ST_IDLE;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (step_q == DIV_LAST) begin
						for (int i = 0; i < ftos_pkg::AXES - 1; i++) begin
							off_q[i] <= off_q[i+1];
						end
						off_q[ftos_pkg::AXES-1] <= mean_wb;
						step_q <= '0;
						if (axis_q == AXIS_LAST) begin
							axis_q    <= '0;
							cal_cnt_q <= cal_cnt_q + 1'b1;
							state_q   <= ST_IDLE;
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SMOOTH: begin
					for (int i = 0; i < ftos_pkg::AXES - 1; i++) begin
						off_q[i] <= off_q[i+1];
						sm_q[i]  <= sm_q[i+1];
					end
					off_q[ftos_pkg::AXES-1] <= off_q[0];
					sm_q[ftos_pkg::AXES-1]  <= sm_new;
					if (axis_q == AXIS_LAST) begin
						axis_q  <= '0;
						step_q  <= '0;
						state_q <= ST_SQ;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end
				ST_SQ: begin
					if (step_q == SQ_LAST) begin
						for (int i = 0; i < ftos_pkg::AXES - 1; i++) begin
							sm_q[i] <= sm_q[i+1];
						end
						sm_q[ftos_pkg::AXES-1] <= sm_q[0];
						step_q <= '0;
						axis_q <= (axis_q == AXIS_LAST) ? '0 : axis_q + 1'b1;
						if (axis_q == FORCE_LAST || axis_q == AXIS_LAST) begin
							state_q <= ST_ROOT;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (step_q == ROOT_LAST) begin
						step_q  <= '0;
						state_q <= (axis_q == '0) ? ST_OUT : ST_SQ;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					for (int i = 0; i < ftos_pkg::AXES; i++) begin
						x_q[i] <= s_tdata[i*ftos_pkg::IN_W +: ftos_pkg::IN_W];
					end
					acc_q <= '0;
				end
			end
			ST_CAL, ST_SMOOTH: begin
				for (int i = 0; i < ftos_pkg::AXES - 1; i++) begin
					x_q[i] <= x_q[i+1];
				end
				x_q[ftos_pkg::AXES-1] <= x_q[0];
			end
			ST_DIV: begin
				if (step_q == '0) begin
					dq_q   <= off_abs;
					neg_q  <= off_q[0][ftos_pkg::SUM_W-1];
					drem_q <= '0;
				end else if (step_q != DIV_LAST) begin
					dq_q   <= {dq_q[ftos_pkg::SUM_W-2:0], div_ge};
					drem_q <= drem_d;
				end
			end
			ST_SQ: begin
				if (step_q == '0) begin
					mcand_q <= ftos_pkg::SQ_W'(sm_abs);
					mpl_q   <= sm_abs;
				end else begin
					if (mpl_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q <= mcand_q << 1;
					mpl_q   <= mpl_q >> 1;
				end
				srem_q <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				srem_q <= srem_d;
				root_q <= root_d;
				acc_q  <= acc_q << 2;
				if (step_q == ROOT_LAST) begin
					if (axis_q == '0) begin
						tmag_q <= root_d;
					end else begin
						fmag_q <= root_d;
					end
				end
			end
			ST_OUT: begin
				if (out_load) begin
					for (int i = 0; i < ftos_pkg::AXES; i++) begin
						out_q[i*ftos_pkg::AVG_W +: ftos_pkg::AVG_W] <= sm_q[i];
					end
					out_q[ftos_pkg::AXES*ftos_pkg::AVG_W +: ftos_pkg::AVG_W]       <= fmag_q;
					out_q[(ftos_pkg::AXES + 1)*ftos_pkg::AVG_W +: ftos_pkg::AVG_W] <= tmag_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/ftos_checker.sv
// ftos_checker: port-level checks of force_torque_offset_smoother, bound to the top level
// depends on ftos_pkg for field widths and the magnitude bound
module ftos_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [ftos_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int FMAG_LO = ftos_pkg::AXES * ftos_pkg::AVG_W;

	// stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped or changed while stalled");

	// no result can follow an input word in the very next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result word appeared right after an input word");

	// magnitudes stay within the bound of three full-scale axes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[FMAG_LO +: ftos_pkg::AVG_W] <= ftos_pkg::AVG_W'(ftos_pkg::MAG_MAX)
			&& m_tdata[FMAG_LO + ftos_pkg::AVG_W +: ftos_pkg::AVG_W]
				<= ftos_pkg::AVG_W'(ftos_pkg::MAG_MAX))
		else $error("magnitude out of range");

	// zero force magnitude only for a zero force vector
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[FMAG_LO +: ftos_pkg::AVG_W] == '0)
			|-> m_tdata[3*ftos_pkg::AVG_W-1:0] == '0)
		else $error("zero force magnitude with nonzero force averages");

endmodule

bind force_torque_offset_smoother ftos_checker u_ftos_checker (.*);

FILE: tb/sv/ftos_result_check.sv
`timescale 1ns / 1ps
// ftos_result_check: watches the sample, result and enable channels of the smoother,
// predicts each result word and compares it field by field; uses ftos_pkg
module ftos_result_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [ftos_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [ftos_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic                             cfg_data,
	output int                               pending,
	output int                               fails
);
	import ftos_pkg::*;

	localparam int NFIELDS = AXES + 2;

	logic                  enabled;
	int                    cal_taken;
	longint                axis_bias [AXES];
	longint                axis_avg [AXES];
	logic [OUT_DATA_W-1:0] awaited_words [$];
	int                    reports;

	function automatic string field_name(int f);
		case (f)
			0: return "avg_force_x";
			1: return "avg_force_y";
			2: return "avg_force_z";
			3: return "avg_torque_x";
			4: return "avg_torque_y";
			5: return "avg_torque_z";
			6: return "force_magnitude";
			default: return "torque_magnitude";
		endcase
	endfunction

	function automatic longint floor_sqrt(longint n);
		longint root;
		longint cand;
		root = 0;
		for (int b = 26; b >= 0; b--) begin
			cand = root | (64'sd1 << b);
			if (cand * cand <= n)
				root = cand;
		end
		return root;
	endfunction

	task automatic clear_state();
		cal_taken = 0;
		for (int i = 0; i < AXES; i++) begin
			axis_bias[i] = 0;
			axis_avg[i] = 0;
		end
	endtask

	task automatic absorb_word(input logic mode, input logic [IN_DATA_W-1:0] data);
		longint                smp;
		longint                force_sq;
		longint                torque_sq;
		logic [OUT_DATA_W-1:0] word;
		if (mode) begin
			clear_state();
			return;
		end
		if (!enabled)
			return;
		if (cal_taken < CAL_SAMPLES) begin
			for (int i = 0; i < AXES; i++) begin
				smp = sample_t'(data[i*IN_W +: IN_W]);
				axis_bias[i] += smp;
			end
			cal_taken++;
			return;
		end
		if (cal_taken == CAL_SAMPLES) begin
			for (int i = 0; i < AXES; i++)
				axis_bias[i] = axis_bias[i] / CAL_SAMPLES;
			cal_taken++;
			return;
		end
		force_sq = 0;
		torque_sq = 0;
		for (int i = 0; i < AXES; i++) begin
			smp = sample_t'(data[i*IN_W +: IN_W]);
			axis_avg[i] = (3 * axis_avg[i] + axis_bias[i] - smp) >>> 2;
			word[i*AVG_W +: AVG_W] = axis_avg[i][AVG_W-1:0];
			if (i < 3)
				force_sq += axis_avg[i] * axis_avg[i];
			else
				torque_sq += axis_avg[i] * axis_avg[i];
		end
		word[AXES*AVG_W +: AVG_W] = AVG_W'(floor_sqrt(force_sq));
		word[(AXES+1)*AVG_W +: AVG_W] = AVG_W'(floor_sqrt(torque_sq));
		awaited_words.push_back(word);
	endtask

	task automatic compare_result(input logic [OUT_DATA_W-1:0] got);
		logic [OUT_DATA_W-1:0] want;
		if (awaited_words.size() == 0) begin
			if (reports < 10)
				$display("result word %h arrived with none expected", got);
			reports++;
			fails++;
			return;
		end
		want = awaited_words.pop_front();
		for (int f = 0; f < NFIELDS; f++) begin
			if (got[f*AVG_W +: AVG_W] !== want[f*AVG_W +: AVG_W]) begin
				if (reports < 10)
					$display("%s: expected %h, got %h", field_name(f),
						want[f*AVG_W +: AVG_W], got[f*AVG_W +: AVG_W]);
				reports++;
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled = 1'b1;
			clear_state();
			awaited_words.delete();
			reports = 0;
			fails = 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_result(m_tdata);
			if (cfg_valid && cfg_ready)
				enabled = cfg_data;
			if (s_tvalid && s_tready)
				absorb_word(s_tuser, s_tdata);
		end
		pending = awaited_words.size();
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for force_torque_offset_smoother
// drives the sample, result and enable channels; checking is done by ftos_result_check
module tb;
	import ftos_pkg::*;

	typedef enum int {ANY_VALUE, EDGE_VALUE, NEAR_CENTRE} value_style_e;

	localparam int              SETTLE_CYCLES  = 300;
	localparam int              SQUEEZE_CYCLES = 800;
	localparam int              WATCHDOG_LIMIT = 10000;
	localparam int              ITEM_TARGET    = 650;
	localparam logic [IN_W-1:0] S_MAX          = 24'h7FFFFF;
	localparam logic [IN_W-1:0] S_MIN          = 24'h800000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data = 1'b1;

	logic [IN_W-1:0] centre [AXES];
	int              items_sent = 0;
	int              stall_cycles = 0;
	bit              gaps_on = 1'b1;
	bit              en_now = 1'b1;
	bit              squeeze_req = 1'b0;
	int              pending;
	int              fails;

	always #5 clk = ~clk;

	force_torque_offset_smoother u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ftos_result_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.fails     (fails)
	);

	function automatic logic [IN_W-1:0] corner_value(int j);
		case (j % 5)
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return '1;
			default: return 24'h000001;
		endcase
	endfunction

	function automatic logic [IN_DATA_W-1:0] corner_word(int k);
		logic [IN_DATA_W-1:0] w;
		for (int i = 0; i < AXES; i++)
			w[i*IN_W +: IN_W] = corner_value(k + i);
		return w;
	endfunction

	function automatic logic [IN_DATA_W-1:0] make_word(value_style_e s);
		logic [IN_DATA_W-1:0] w;
		for (int i = 0; i < AXES; i++) begin
			case (s)
				ANY_VALUE: w[i*IN_W +: IN_W] = IN_W'($urandom());
				EDGE_VALUE: w[i*IN_W +: IN_W] = corner_value($urandom_range(0, 4));
				default: w[i*IN_W +: IN_W] = centre[i] + IN_W'($urandom_range(0, 4095))
					- IN_W'(2048);
			endcase
		end
		return w;
	endfunction

	task automatic send_word(input logic mode, input logic [IN_DATA_W-1:0] data);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!mode && en_now)
			items_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_enable(input logic value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		en_now = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_session(input bit squeeze, input bit pause);
		value_style_e cal_style;
		int           n_out;
		int           pick;
		for (int i = 0; i < AXES; i++)
			centre[i] = IN_W'($urandom_range(0, 24'h3FFFFF) - 24'h200000);
		pick = $urandom_range(0, 9);
		cal_style = (pick < 6) ? NEAR_CENTRE : (pick < 8) ? ANY_VALUE : EDGE_VALUE;
		send_word(1'b1, make_word(ANY_VALUE));
		// calibration cut short or just completed, then a clear
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, CAL_SAMPLES + 1))
				send_word(1'b0, make_word(cal_style));
			send_word(1'b1, make_word(ANY_VALUE));
		end
		repeat (CAL_SAMPLES + 1) send_word(1'b0, make_word(cal_style));
		n_out = $urandom_range(30, 70);
		for (int k = 0; k < n_out; k++) begin
			if (squeeze && k == 4)
				squeeze_req = 1'b1;
			if (pause && k == n_out / 2) begin
				settle();
				write_enable(1'b0);
				repeat ($urandom_range(2, 8)) send_word(1'b0, make_word(ANY_VALUE));
				settle();
				write_enable(1'b1);
			end
			pick = $urandom_range(0, 15);
			send_word(1'b0, make_word(pick == 0 ? EDGE_VALUE :
				pick == 1 ? ANY_VALUE : NEAR_CENTRE));
		end
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				m_tready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
				squeeze_req = 1'b0;
			end
			m_tready <= !(gaps_on && $urandom_range(0, 99) < 7);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_enable(1'b1);

		send_word(1'b1, '1);
		for (int k = 0; k < CAL_SAMPLES + 1; k++)
			send_word(1'b0, corner_word(k));
		for (int k = 0; k < 10; k++)
			send_word(1'b0, corner_word(3 * k + 1));
		send_word(1'b0, {AXES{S_MAX}});
		send_word(1'b0, {AXES{S_MIN}});

		// bias at one limit, samples at the other
		send_word(1'b1, '0);
		repeat (CAL_SAMPLES + 1) send_word(1'b0, {AXES{S_MIN}});
		repeat (12) send_word(1'b0, {AXES{S_MAX}});
		repeat (3) send_word(1'b0, {AXES{S_MIN}});
		send_word(1'b1, '0);
		repeat (CAL_SAMPLES + 1) send_word(1'b0, {AXES{S_MAX}});
		repeat (12) send_word(1'b0, {AXES{S_MIN}});

		// disabled samples are dropped, a clear still takes effect
		settle();
		write_enable(1'b0);
		repeat (4) send_word(1'b0, make_word(ANY_VALUE));
		send_word(1'b1, make_word(ANY_VALUE));
		repeat (3) send_word(1'b0, make_word(ANY_VALUE));
		settle();
		write_enable(1'b1);
		for (int k = 0; k < CAL_SAMPLES + 5; k++)
			send_word(1'b0, corner_word(2 * k));

		for (int n = 0; items_sent < ITEM_TARGET; n++) begin
			gaps_on = (n != 1);
			run_session(n == 0 || n == 3, n % 2 == 0);
		end
		gaps_on = 1'b1;
		settle();
		if (fails == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: force_torque_offset_smoother.f
src/ftos_pkg.sv
src/force_torque_offset_smoother.sv
src/ftos_checker.sv
tb/sv/ftos_result_check.sv
tb/sv/tb.sv
